@@ src/ycu_pkg.sv @@
`timescale 1ns / 1ps

package ycu_pkg;

   // Sample and accumulator widths
   localparam int PIX_W = 8;
   localparam int SUM_W = 10;
   localparam int ACC_W = 18;

   // Register stages from an accepted transfer to the result strobe
   localparam int PIPE_DEPTH = 4;

   // Integer BT.601 coefficients, 6-bit fraction
   localparam int Y_OFFSET   = 16;
   localparam int C_OFFSET   = 128;
   localparam int K_Y        = 74;
   localparam int K_R_CR     = 102;
   localparam int K_G_CR     = 52;
   localparam int K_G_CB     = 25;
   localparam int K_B_CB     = 129;
   localparam int ROUND_HALF = 32;
   localparam int FRAC_BITS  = 6;
   localparam int PIX_MAX    = 255;

   // Quad position inside the pixel array
   localparam int POS_TL = 0;
   localparam int POS_TR = 1;
   localparam int POS_BL = 2;
   localparam int POS_BR = 3;
   localparam int NUM_POS = 4;

   typedef logic [PIX_W-1:0] pix_byte_type;

   typedef struct packed {
      pix_byte_type luma_top_left;
      pix_byte_type luma_top_right;
      pix_byte_type luma_bottom_left;
      pix_byte_type luma_bottom_right;
      pix_byte_type cb_here;
      pix_byte_type cr_here;
      pix_byte_type cb_right;
      pix_byte_type cr_right;
      pix_byte_type cb_below;
      pix_byte_type cr_below;
      pix_byte_type cb_diagonal;
      pix_byte_type cr_diagonal;
   } req_type;

   typedef struct packed {
      pix_byte_type red_top_left;
      pix_byte_type green_top_left;
      pix_byte_type blue_top_left;
      pix_byte_type red_top_right;
      pix_byte_type green_top_right;
      pix_byte_type blue_top_right;
      pix_byte_type red_bottom_left;
      pix_byte_type green_bottom_left;
      pix_byte_type blue_bottom_left;
      pix_byte_type red_bottom_right;
      pix_byte_type green_bottom_right;
      pix_byte_type blue_bottom_right;
   } rsp_type;

   // One pixel with its upsampled chroma
   typedef struct packed {
      pix_byte_type luma;
      pix_byte_type cb;
      pix_byte_type cr;
   } pix_type;

   // One converted pixel
   typedef struct packed {
      pix_byte_type red;
      pix_byte_type green;
      pix_byte_type blue;
   } rgb_type;

endpackage

@@ src/ycu_chroma.sv @@
`timescale 1ns / 1ps

module ycu_chroma (
   input  logic               clock,
   input  ycu_pkg::req_type   req_data,
   input  logic               load,
   output ycu_pkg::pix_type   quad_ff [ycu_pkg::NUM_POS]
);

   localparam int PW = ycu_pkg::PIX_W;
   localparam int SW = ycu_pkg::SUM_W;

   logic [PW:0]   cb_tr_sum, cr_tr_sum, cb_bl_sum, cr_bl_sum;
   logic [SW-1:0] cb_br_sum, cr_br_sum;
   ycu_pkg::pix_type quad_in [ycu_pkg::NUM_POS];

   // Floor averages toward the right, below and diagonal neighbours
   always_comb begin
      cb_tr_sum = {1'b0, req_data.cb_here} + {1'b0, req_data.cb_right};
      cr_tr_sum = {1'b0, req_data.cr_here} + {1'b0, req_data.cr_right};
      cb_bl_sum = {1'b0, req_data.cb_here} + {1'b0, req_data.cb_below};
      cr_bl_sum = {1'b0, req_data.cr_here} + {1'b0, req_data.cr_below};
      cb_br_sum = SW'(cb_tr_sum) + SW'({1'b0, req_data.cb_below})
                  + SW'({1'b0, req_data.cb_diagonal});
      cr_br_sum = SW'(cr_tr_sum) + SW'({1'b0, req_data.cr_below})
                  + SW'({1'b0, req_data.cr_diagonal});

      quad_in[ycu_pkg::POS_TL].luma = req_data.luma_top_left;
      quad_in[ycu_pkg::POS_TL].cb   = req_data.cb_here;
      quad_in[ycu_pkg::POS_TL].cr   = req_data.cr_here;
      quad_in[ycu_pkg::POS_TR].luma = req_data.luma_top_right;
      quad_in[ycu_pkg::POS_TR].cb   = cb_tr_sum[PW:1];
      quad_in[ycu_pkg::POS_TR].cr   = cr_tr_sum[PW:1];
      quad_in[ycu_pkg::POS_BL].luma = req_data.luma_bottom_left;
      quad_in[ycu_pkg::POS_BL].cb   = cb_bl_sum[PW:1];
      quad_in[ycu_pkg::POS_BL].cr   = cr_bl_sum[PW:1];
      quad_in[ycu_pkg::POS_BR].luma = req_data.luma_bottom_right;
      quad_in[ycu_pkg::POS_BR].cb   = cb_br_sum[SW-1:2];
      quad_in[ycu_pkg::POS_BR].cr   = cr_br_sum[SW-1:2];
   end

   // Capture the quad on each accepted transfer
   always_ff @(posedge clock) begin
      if (load) begin
         quad_ff <= quad_in;
      end
   end

endmodule

@@ src/ycu_pixel.sv @@
`timescale 1ns / 1ps

module ycu_pixel (
   input  logic               clock,
   input  ycu_pkg::pix_type   pix,
   output ycu_pkg::rgb_type   rgb_ff
);

   localparam int AW = ycu_pkg::ACC_W;
   localparam int PW = ycu_pkg::PIX_W;

   localparam logic signed [AW-1:0] KY    = AW'(ycu_pkg::K_Y);
   localparam logic signed [AW-1:0] KRCR  = AW'(ycu_pkg::K_R_CR);
   localparam logic signed [AW-1:0] KGCR  = AW'(ycu_pkg::K_G_CR);
   localparam logic signed [AW-1:0] KGCB  = AW'(ycu_pkg::K_G_CB);
   localparam logic signed [AW-1:0] KBCB  = AW'(ycu_pkg::K_B_CB);
   localparam logic signed [AW-1:0] YOFS  = AW'(ycu_pkg::Y_OFFSET);
   localparam logic signed [AW-1:0] COFS  = AW'(ycu_pkg::C_OFFSET);
   localparam logic signed [AW-1:0] RND   = AW'(ycu_pkg::ROUND_HALF);
   localparam logic signed [AW-1:0] SATHI = AW'(ycu_pkg::PIX_MAX);

   logic signed [AW-1:0] y_ofs, cb_ofs, cr_ofs;
   logic signed [AW-1:0] prod_y_in, prod_rcr_in, prod_gcr_in, prod_gcb_in, prod_bcb_in;
   logic signed [AW-1:0] prod_y_ff, prod_rcr_ff, prod_gcr_ff, prod_gcb_ff, prod_bcb_ff;
   logic signed [AW-1:0] sum_r_in, sum_g_in, sum_b_in;
   logic signed [AW-1:0] sum_r_ff, sum_g_ff, sum_b_ff;
   logic signed [AW-1:0] q_r, q_g, q_b;
   ycu_pkg::rgb_type     rgb_in;

   function automatic ycu_pkg::pix_byte_type saturate(input logic signed [AW-1:0] q);
      ycu_pkg::pix_byte_type res;
      if (q < 0) begin
         res = '0;
      end else if (q > SATHI) begin
         res = PW'(ycu_pkg::PIX_MAX);
      end else begin
         res = q[PW-1:0];
      end
      return res;
   endfunction

   // Remove offsets and form the coefficient products
   always_comb begin
      y_ofs       = signed'(AW'(pix.luma)) - YOFS;
      cb_ofs      = signed'(AW'(pix.cb)) - COFS;
      cr_ofs      = signed'(AW'(pix.cr)) - COFS;
      prod_y_in   = AW'(y_ofs * KY);
      prod_rcr_in = AW'(cr_ofs * KRCR);
      prod_gcr_in = AW'(cr_ofs * KGCR);
      prod_gcb_in = AW'(cb_ofs * KGCB);
      prod_bcb_in = AW'(cb_ofs * KBCB);
   end

   always_ff @(posedge clock) begin
      prod_y_ff   <= prod_y_in;
      prod_rcr_ff <= prod_rcr_in;
      prod_gcr_ff <= prod_gcr_in;
      prod_gcb_ff <= prod_gcb_in;
      prod_bcb_ff <= prod_bcb_in;
   end

   // Combine products per channel and add the rounding half
   always_comb begin
      sum_r_in = prod_y_ff + prod_rcr_ff + RND;
      sum_g_in = prod_y_ff - prod_gcr_ff - prod_gcb_ff + RND;
      sum_b_in = prod_y_ff + prod_bcb_ff + RND;
   end

   always_ff @(posedge clock) begin
      sum_r_ff <= sum_r_in;
      sum_g_ff <= sum_g_in;
      sum_b_ff <= sum_b_in;
   end

   // Drop the fraction with a floor shift and clamp to a byte
   always_comb begin
      q_r          = sum_r_ff >>> ycu_pkg::FRAC_BITS;
      q_g          = sum_g_ff >>> ycu_pkg::FRAC_BITS;
      q_b          = sum_b_ff >>> ycu_pkg::FRAC_BITS;
      rgb_in.red   = saturate(q_r);
      rgb_in.green = saturate(q_g);
      rgb_in.blue  = saturate(q_b);
   end

   always_ff @(posedge clock) begin
      rgb_ff <= rgb_in;
   end

endmodule

@@ src/ycbcr420_upsample_to_rgb.sv @@
`timescale 1ns / 1ps

// Channel   Ports                      Direction  Transfer
// request   start, busy, req_data      in         start high while busy low
// result    rsp_strobe, rsp_data       out        every cycle rsp_strobe is high
//
// Four register stages: chroma averaging, coefficient products, channel sums,
// then floor shift with saturation into the output register.
// One request per cycle is taken.
// busy stays low: the pipeline never stalls, since results cannot be held off.
// Reset clears only the valid bits that travel beside the data.

module ycbcr420_upsample_to_rgb (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ycu_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ycu_pkg::rsp_type rsp_data
);

   localparam int DEPTH = ycu_pkg::PIPE_DEPTH;

   logic             accept;
   logic [DEPTH-1:0] valid_ff, valid_in;
   ycu_pkg::pix_type quad_ff [ycu_pkg::NUM_POS];
   ycu_pkg::rgb_type rgb_ff  [ycu_pkg::NUM_POS];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   ycu_chroma u_chroma (
      .clock    (clock),
      .req_data (req_data),
      .load     (accept),
      .quad_ff  (quad_ff)
   );

   for (genvar p = 0; p < ycu_pkg::NUM_POS; p++) begin : g_pix
      ycu_pixel u_pixel (
         .clock  (clock),
         .pix    (quad_ff[p]),
         .rgb_ff (rgb_ff[p])
      );
   end

   // Advance the valid bits alongside the data stages
   assign valid_in = {valid_ff[DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Drive the result from the pixel output registers
   always_comb begin
      rsp_strobe                  = valid_ff[DEPTH-1];
      rsp_data.red_top_left       = rgb_ff[ycu_pkg::POS_TL].red;
      rsp_data.green_top_left     = rgb_ff[ycu_pkg::POS_TL].green;
      rsp_data.blue_top_left      = rgb_ff[ycu_pkg::POS_TL].blue;
      rsp_data.red_top_right      = rgb_ff[ycu_pkg::POS_TR].red;
      rsp_data.green_top_right    = rgb_ff[ycu_pkg::POS_TR].green;
      rsp_data.blue_top_right     = rgb_ff[ycu_pkg::POS_TR].blue;
      rsp_data.red_bottom_left    = rgb_ff[ycu_pkg::POS_BL].red;
      rsp_data.green_bottom_left  = rgb_ff[ycu_pkg::POS_BL].green;
      rsp_data.blue_bottom_left   = rgb_ff[ycu_pkg::POS_BL].blue;
      rsp_data.red_bottom_right   = rgb_ff[ycu_pkg::POS_BR].red;
      rsp_data.green_bottom_right = rgb_ff[ycu_pkg::POS_BR].green;
      rsp_data.blue_bottom_right  = rgb_ff[ycu_pkg::POS_BR].blue;
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import ycu_pkg::*;

   localparam int RANDOM_QUADS = 2000;
   localparam int QUIET_TAIL   = 300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int NUM_BYTES    = 12;
   localparam int MAX_REPORTS  = 10;

   logic    clock;
   logic    reset;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Quads waiting to be driven, and RGB results still owed by the block
   req_type pending_quads [$];
   rsp_type expected_rgb [$];

   int unsigned cycle_count    = 0;
   int unsigned quads_accepted = 0;
   int unsigned results_seen   = 0;
   int unsigned directed_quads = 0;
   int unsigned error_count    = 0;
   int unsigned gap_left       = 0;
   int unsigned idle_mode      = 0;
   int unsigned mode_left      = 0;
   rsp_type     want_rgb;

   string byte_names [NUM_BYTES] = '{
      "red_top_left", "green_top_left", "blue_top_left",
      "red_top_right", "green_top_right", "blue_top_right",
      "red_bottom_left", "green_bottom_left", "blue_bottom_left",
      "red_bottom_right", "green_bottom_right", "blue_bottom_right"};

   ycbcr420_upsample_to_rgb uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Clamp a fixed-point channel to a pixel byte
   function automatic pix_byte_type saturate_byte(int value);
      if (value < 0)
         return '0;
      if (value > PIX_MAX)
         return pix_byte_type'(PIX_MAX);
      return pix_byte_type'(value);
   endfunction

   // Integer BT.601 conversion of one pixel
   function automatic rgb_type bt601_pixel(int luma, int cb, int cr);
      int      base;
      int      db;
      int      dr;
      rgb_type px;
      base = K_Y * (luma - Y_OFFSET) + ROUND_HALF;
      db   = cb - C_OFFSET;
      dr   = cr - C_OFFSET;
      px.red   = saturate_byte((base + K_R_CR * dr) >>> FRAC_BITS);
      px.green = saturate_byte((base - K_G_CR * dr - K_G_CB * db) >>> FRAC_BITS);
      px.blue  = saturate_byte((base + K_B_CB * db) >>> FRAC_BITS);
      return px;
   endfunction

   // Upsample chroma across the quad by floor averaging, then convert each pixel
   function automatic rsp_type quad_to_rgb(req_type q);
      int      cb_h, cr_h, cb_r, cr_r, cb_b, cr_b, cb_d, cr_d;
      rgb_type px;
      rsp_type rgb;
      cb_h = int'(q.cb_here);
      cr_h = int'(q.cr_here);
      cb_r = int'(q.cb_right);
      cr_r = int'(q.cr_right);
      cb_b = int'(q.cb_below);
      cr_b = int'(q.cr_below);
      cb_d = int'(q.cb_diagonal);
      cr_d = int'(q.cr_diagonal);
      px = bt601_pixel(int'(q.luma_top_left), cb_h, cr_h);
      rgb.red_top_left   = px.red;
      rgb.green_top_left = px.green;
      rgb.blue_top_left  = px.blue;
      px = bt601_pixel(int'(q.luma_top_right), (cb_h + cb_r) >> 1, (cr_h + cr_r) >> 1);
      rgb.red_top_right   = px.red;
      rgb.green_top_right = px.green;
      rgb.blue_top_right  = px.blue;
      px = bt601_pixel(int'(q.luma_bottom_left), (cb_h + cb_b) >> 1, (cr_h + cr_b) >> 1);
      rgb.red_bottom_left   = px.red;
      rgb.green_bottom_left = px.green;
      rgb.blue_bottom_left  = px.blue;
      px = bt601_pixel(int'(q.luma_bottom_right), (cb_h + cb_r + cb_b + cb_d) >> 2,
                       (cr_h + cr_r + cr_b + cr_d) >> 2);
      rgb.red_bottom_right   = px.red;
      rgb.green_bottom_right = px.green;
      rgb.blue_bottom_right  = px.blue;
      return rgb;
   endfunction

   // Flat quad: same luma everywhere, same chroma at every sample
   function automatic req_type flat_quad(int luma, int cb, int cr);
      req_type q;
      q.luma_top_left     = pix_byte_type'(luma);
      q.luma_top_right    = pix_byte_type'(luma);
      q.luma_bottom_left  = pix_byte_type'(luma);
      q.luma_bottom_right = pix_byte_type'(luma);
      q.cb_here     = pix_byte_type'(cb);
      q.cb_right    = pix_byte_type'(cb);
      q.cb_below    = pix_byte_type'(cb);
      q.cb_diagonal = pix_byte_type'(cb);
      q.cr_here     = pix_byte_type'(cr);
      q.cr_right    = pix_byte_type'(cr);
      q.cr_below    = pix_byte_type'(cr);
      q.cr_diagonal = pix_byte_type'(cr);
      return q;
   endfunction

   // Random byte close to a center value, clamped to the byte range
   function automatic pix_byte_type near_byte(int center, int spread);
      int v;
      v = center + $urandom_range(2 * spread, 0) - spread;
      if (v < 0)
         v = 0;
      if (v > PIX_MAX)
         v = PIX_MAX;
      return pix_byte_type'(v);
   endfunction

   // Byte biased toward range ends and conversion offsets
   function automatic pix_byte_type corner_byte();
      case ($urandom_range(5, 0))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return pix_byte_type'(Y_OFFSET);
         3:       return pix_byte_type'(C_OFFSET);
         4:       return 8'd235;
         default: return pix_byte_type'($urandom_range(255, 0));
      endcase
   endfunction

   // Random quad of one of several flavors: noise, natural image, corners, edge clamp
   function automatic req_type random_quad();
      req_type q;
      int      y0;
      int      cb0;
      int      cr0;
      int      flavor;
      flavor = $urandom_range(9, 0);
      q = req_type'({$urandom, $urandom, $urandom});
      if (flavor >= 3 && flavor <= 5) begin
         y0  = $urandom_range(255, 0);
         cb0 = $urandom_range(255, 0);
         cr0 = $urandom_range(255, 0);
         q.luma_top_left     = near_byte(y0, 12);
         q.luma_top_right    = near_byte(y0, 12);
         q.luma_bottom_left  = near_byte(y0, 12);
         q.luma_bottom_right = near_byte(y0, 12);
         q.cb_here     = near_byte(cb0, 6);
         q.cb_right    = near_byte(cb0, 6);
         q.cb_below    = near_byte(cb0, 6);
         q.cb_diagonal = near_byte(cb0, 6);
         q.cr_here     = near_byte(cr0, 6);
         q.cr_right    = near_byte(cr0, 6);
         q.cr_below    = near_byte(cr0, 6);
         q.cr_diagonal = near_byte(cr0, 6);
      end else if (flavor >= 6 && flavor <= 7) begin
         q = req_type'({corner_byte(), corner_byte(), corner_byte(), corner_byte(),
                        corner_byte(), corner_byte(), corner_byte(), corner_byte(),
                        corner_byte(), corner_byte(), corner_byte(), corner_byte()});
      end else if (flavor >= 8) begin
         // right or bottom image edge: the feeder repeats the border sample
         if ($urandom_range(1, 0)) begin
            q.cb_right    = q.cb_here;
            q.cr_right    = q.cr_here;
            q.cb_diagonal = q.cb_below;
            q.cr_diagonal = q.cr_below;
         end
         if ($urandom_range(1, 0)) begin
            q.cb_below    = q.cb_here;
            q.cr_below    = q.cr_here;
            q.cb_diagonal = q.cb_right;
            q.cr_diagonal = q.cr_right;
         end
      end
      return q;
   endfunction

   // Driver: record each accepted transfer, then hold, idle or present the next quad
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && busy === 1'b0) begin
            expected_rgb.push_back(quad_to_rgb(req_data));
            quads_accepted++;
         end
         if (!(start && busy !== 1'b0)) begin
            if (mode_left == 0) begin
               idle_mode = $urandom_range(2, 0);
               mode_left = $urandom_range(80, 16);
            end
            mode_left--;
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_quads.size() == 0) begin
               start <= 1'b0;
            end else if (pending_quads.size() > QUIET_TAIL && idle_mode != 0 &&
                         $urandom_range(idle_mode == 1 ? 9 : 2, 0) == 0) begin
               gap_left = $urandom_range(10, 1) - 1;
               start <= 1'b0;
            end else begin
               req_data <= pending_quads.pop_front();
               start    <= 1'b1;
            end
         end
      end
   end

   // Monitor: compare every strobed result with the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe !== 1'b0 && rsp_strobe !== 1'b1) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("ERROR: rsp_strobe unknown at cycle %0d", cycle_count);
         end else if (rsp_strobe) begin
            results_seen++;
            if (expected_rgb.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("ERROR: unexpected result %h at cycle %0d", rsp_data, cycle_count);
            end else begin
               want_rgb = expected_rgb.pop_front();
               for (int i = 0; i < NUM_BYTES; i++) begin
                  if (rsp_data[8*(NUM_BYTES-1-i) +: 8] !== want_rgb[8*(NUM_BYTES-1-i) +: 8]) begin
                     error_count++;
                     if (error_count <= MAX_REPORTS)
                        $display("ERROR: result %0d %s expected %0d got %0d",
                                 results_seen, byte_names[i],
                                 want_rgb[8*(NUM_BYTES-1-i) +: 8],
                                 rsp_data[8*(NUM_BYTES-1-i) +: 8]);
                  end
               end
            end
         end
      end
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_rgb.size());
         $display("ycbcr420_upsample_to_rgb regression: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;

      // Directed quads: range ends, neutral gray, rounding tie, saturation,
      // distinct right and lower neighbours, floor averaging, bit patterns
      pending_quads.push_back(flat_quad(0, 0, 0));
      pending_quads.push_back(flat_quad(255, 255, 255));
      pending_quads.push_back(flat_quad(16, 128, 128));
      pending_quads.push_back(flat_quad(235, 128, 128));
      pending_quads.push_back(flat_quad(32, 128, 128));
      pending_quads.push_back(flat_quad(255, 128, 255));
      pending_quads.push_back(flat_quad(0, 255, 0));
      pending_quads.push_back(flat_quad(255, 0, 0));
      pending_quads.push_back(flat_quad(0, 0, 255));
      pending_quads.push_back(flat_quad(128, 255, 255));
      pending_quads.push_back(req_type'({8'd128, 8'd128, 8'd128, 8'd128,
                                         8'd0, 8'd0, 8'd255, 8'd0,
                                         8'd0, 8'd255, 8'd0, 8'd0}));
      pending_quads.push_back(req_type'({8'd128, 8'd128, 8'd128, 8'd128,
                                         8'd0, 8'd0, 8'd0, 8'd255,
                                         8'd255, 8'd0, 8'd0, 8'd0}));
      pending_quads.push_back(req_type'({8'd100, 8'd100, 8'd100, 8'd100,
                                         8'd1, 8'd1, 8'd2, 8'd2,
                                         8'd2, 8'd2, 8'd2, 8'd2}));
      pending_quads.push_back(req_type'({8'd200, 8'd200, 8'd200, 8'd200,
                                         8'd255, 8'd255, 8'd255, 8'd255,
                                         8'd255, 8'd255, 8'd254, 8'd254}));
      pending_quads.push_back(req_type'({8'd128, 8'd128, 8'd128, 8'd128,
                                         8'd0, 8'd0, 8'd0, 8'd0,
                                         8'd0, 8'd0, 8'd255, 8'd255}));
      pending_quads.push_back(req_type'({8'd0, 8'd85, 8'd170, 8'd255,
                                         8'd128, 8'd128, 8'd128, 8'd128,
                                         8'd128, 8'd128, 8'd128, 8'd128}));
      pending_quads.push_back(req_type'({8'hAA, 8'h55, 8'hAA, 8'h55,
                                         8'hAA, 8'h55, 8'hAA, 8'h55,
                                         8'hAA, 8'h55, 8'hAA, 8'h55}));
      pending_quads.push_back(req_type'({8'h55, 8'hAA, 8'h55, 8'hAA,
                                         8'h55, 8'hAA, 8'h55, 8'hAA,
                                         8'h55, 8'hAA, 8'h55, 8'hAA}));
      pending_quads.push_back(req_type'({8'd60, 8'd60, 8'd60, 8'd60,
                                         8'd255, 8'd255, 8'd0, 8'd0,
                                         8'd0, 8'd0, 8'd0, 8'd0}));
      pending_quads.push_back(req_type'({8'h80, 8'h7F, 8'h10, 8'h0F,
                                         8'h80, 8'h7F, 8'h7F, 8'h80,
                                         8'h80, 8'h7F, 8'h7F, 8'h80}));
      directed_quads = pending_quads.size();

      // Random quads
      repeat (RANDOM_QUADS)
         pending_quads.push_back(random_quad());

      // Hold reset, then release it on a clock edge
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Drain: every quad transferred, every result back, then a short settle
      while (pending_quads.size() > 0 || start)
         @(posedge clock);
      while (expected_rgb.size() > 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 8) @(posedge clock);

      $display("Converted %0d quads (%0d directed, rest random with idle bursts).",
               quads_accepted, directed_quads);
      $display("Checked %0d results over %0d cycles, %0d mismatches.",
               results_seen, cycle_count, error_count);
      if (error_count == 0 && expected_rgb.size() == 0) begin
         $display("ycbcr420_upsample_to_rgb regression: pass");
      end else begin
         $display("ycbcr420_upsample_to_rgb regression: fail");
      end
      $finish;
   end

endmodule
